/* rtl/i2f_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2f_pkg;

    // operand and result widths
    localparam int INT_W  = 32;
    localparam int FLT_W  = 32;
    localparam int FRAC_W = 23;
    localparam int EXP_W  = 8;
    localparam int LEAD_W = $clog2(INT_W);

    // exponent bias and the largest exponent this block can produce
    localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;
    localparam logic [EXP_W-1:0] EXP_MAX  = 8'd158;

    // number of register stages between input acceptance and output
    localparam int PIPE_DEPTH = 4;

endpackage

`default_nettype wire

/* rtl/int32_to_float32_convert.sv */
`timescale 1ns / 1ps
`default_nettype none

// int32 to ieee 754 single conversion, round to nearest, ties to even
//
// channels: the slave side (s_axis_*) takes one signed 32-bit integer per item,
// and the master side (m_axis_*) returns the 32-bit float encoding of it
// (sign bit 31, biased exponent 30..23, fraction 22..0)
//
// pipeline: an accepted item passes through four register stages, sign and
// magnitude, leading-one detect, normalizing shift, and round and pack, and
// its result then shows on m_axis_tvalid
// throughput: one item per cycle, sustained, while the receiver takes results
//
// stall: all stages advance together; when the output register holds a
// result the receiver has not taken, s_axis_tready drops and every stage
// holds, so no item is lost or repeated; a bubble in the output register
// lets the pipeline advance
//
// reset: synchronous, active low; it clears every stage valid bit, so the
// block comes out of reset empty and ready with no result pending
module int32_to_float32_convert (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // slave side
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [i2f_pkg::INT_W-1:0]      s_axis_tdata,   // [31:0] int_value
    // master side
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [i2f_pkg::FLT_W-1:0]      m_axis_tdata    // [31:0] float_bits
);

    localparam int INT_W  = i2f_pkg::INT_W;
    localparam int FLT_W  = i2f_pkg::FLT_W;
    localparam int FRAC_W = i2f_pkg::FRAC_W;
    localparam int EXP_W  = i2f_pkg::EXP_W;
    localparam int LEAD_W = i2f_pkg::LEAD_W;

    // stage 1: sign and magnitude
    logic              r1_valid, r1_sign, r1_zero;
    logic [INT_W-1:0]  r1_mag;

    // stage 2: leading one position
    logic              r2_valid, r2_sign, r2_zero;
    logic [INT_W-1:0]  r2_mag;
    logic [LEAD_W-1:0] r2_lead;

    // stage 3: normalized magnitude, leading one at the top bit
    logic              r3_valid, r3_sign, r3_zero;
    logic [INT_W-1:0]  r3_norm;
    logic [EXP_W-1:0]  r3_expo;

    // stage 4: output register
    logic              r4_valid;
    logic [FLT_W-1:0]  r4_data;

    // one enable moves the whole pipe
    logic w_adv;
    assign w_adv         = !r4_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // next values
    logic [INT_W-1:0]  n1_mag;
    logic [LEAD_W-1:0] n2_lead;
    logic [INT_W-1:0]  n3_norm;
    logic [EXP_W-1:0]  n3_expo;
    logic              n4_inc;
    logic [FLT_W-2:0]  n4_body;
    logic [FLT_W-1:0]  n4_data;

    // two's complement negate; the most negative value maps onto 2^31 itself
    assign n1_mag = s_axis_tdata[INT_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

    // priority encoder, highest set bit wins
    always_comb begin
        n2_lead = '0;
        for (int i = 0; i < INT_W; i++) begin
            if (r1_mag[i]) begin
                n2_lead = LEAD_W'(i);
            end
        end
    end

    // shift by (INT_W-1 - lead), which is ~lead for a power-of-two width
    assign n3_norm = r2_mag << (~r2_lead);
    assign n3_expo = EXP_W'(r2_lead) + i2f_pkg::EXP_BIAS;

    // guard is the top dropped bit, sticky the rest, lsb the kept fraction lsb
    assign n4_inc  = r3_norm[INT_W-FRAC_W-2]
                     && (r3_norm[INT_W-FRAC_W-1] || (|r3_norm[INT_W-FRAC_W-3:0]));
    // a carry out of the fraction lands in the exponent
    assign n4_body = {r3_expo, r3_norm[INT_W-2 -: FRAC_W]} + (FLT_W-1)'(n4_inc);
    assign n4_data = r3_zero ? '0 : {r3_sign, n4_body};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sign <= s_axis_tdata[INT_W-1];
            r1_zero <= (s_axis_tdata == '0);
            r1_mag  <= n1_mag;

            r2_sign <= r1_sign;
            r2_zero <= r1_zero;
            r2_mag  <= r1_mag;
            r2_lead <= n2_lead;

            r3_sign <= r2_sign;
            r3_zero <= r2_zero;
            r3_norm <= n3_norm;
            r3_expo <= n3_expo;

            r4_data <= n4_data;
        end
    end

    assign m_axis_tvalid = r4_valid;
    assign m_axis_tdata  = r4_data;

endmodule

`default_nettype wire

/* rtl/i2f_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2f_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire [i2f_pkg::INT_W-1:0]   s_axis_tdata,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [i2f_pkg::FLT_W-1:0]   m_axis_tdata
);

    // a result waiting for the receiver stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or vanished");

    // the pipe never refuses input while the receiver is taking results
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // exponent stays within what a 32-bit integer can reach
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:23] <= i2f_pkg::EXP_MAX))
        else $error("exponent out of range");

    // a zero exponent only comes with positive zero
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[30:23] == '0)) |-> (m_axis_tdata == '0))
        else $error("denormal or negative zero produced");

endmodule

bind int32_to_float32_convert i2f_checker u_i2f_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
